[sv/rrog_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrog_pkg
// Shared types, codes and the sine table builder for the range ring grid.
// ----------------------------------------------------------------------------
package rrog_pkg;

   localparam int ACTION_W    = 2;
   localparam int INDEX_W     = 8;
   localparam int DIST_W      = 16;
   localparam int RSEL_W      = 5;
   localparam int CELL_W      = 5;
   localparam int STATUS_W    = 2;
   localparam int ROW_BITS_W  = 21;
   localparam int RADIUS_W    = DIST_W + 1;
   localparam int MAG_W       = 15;
   localparam int PROD_W      = RADIUS_W + MAG_W;
   localparam int ROUND_SHIFT = 21;
   localparam int OFF_W       = PROD_W + 1 - ROUND_SHIFT;
   localparam int POS_W       = OFF_W + 1;
   localparam int IDX_W       = 6;
   localparam int CNT_W       = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_MARKED    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BEYOND    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OFF_GRID  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SENSOR_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_STEP   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LIMIT  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROBOT_RADIUS = 2'd3;

   localparam logic [CNT_W-1:0]  RESET_SENSOR_COUNT = 9'd8;
   localparam logic [DIST_W-1:0] RESET_ANGLE_STEP   = 16'd8192;
   localparam logic [DIST_W-1:0] RESET_RANGE_LIMIT  = 16'd512;
   localparam logic [DIST_W-1:0] RESET_ROBOT_RADIUS = 16'd128;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // ceil(2^42 / d) for the series denominators; exact for dividends below 2^34
   localparam int          RECIP_SHIFT = 42;
   localparam logic [63:0] RECIP_6     = ((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6;
   localparam logic [63:0] RECIP_20    = ((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20;
   localparam logic [63:0] RECIP_42    = ((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42;
   localparam logic [63:0] RECIP_72    = ((64'd1 << RECIP_SHIFT) + 64'd71) / 64'd72;
   localparam logic [63:0] RECIP_110   = ((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110;
   localparam logic [63:0] RECIP_156   = ((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [INDEX_W-1:0]  sensor_index;
      logic [DIST_W-1:0]   distance;
      logic [RSEL_W-1:0]   row_select;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0]     cell_row;
      logic [CELL_W-1:0]     cell_col;
      logic [STATUS_W-1:0]   status;
      logic [ROW_BITS_W-1:0] row_bits;
   } rsp_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [STATUS_W-1:0] status;
      logic [DIST_W-1:0]   angle;
      logic [RADIUS_W-1:0] radius;
      logic [RSEL_W-1:0]   row_select;
   } cmd_type;

   // Q15 magnitude of sin(r / 2^(bits-2) * pi/2), Q30 Taylor series to x^13.
   function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned r,
                                                     input int unsigned bits);
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  recip;
      logic [127:0] wide;
      x    = (64'(r) * HALF_PI_Q30) >> (bits - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int unsigned n = 1; n <= 6; n++) begin
         case (n)
            1: recip = RECIP_6;
            2: recip = RECIP_20;
            3: recip = RECIP_42;
            4: recip = RECIP_72;
            5: recip = RECIP_110;
            default: recip = RECIP_156;
         endcase
         term = (term * x2) >> 30;
         wide = 128'(term) * 128'(recip);
         term = wide[RECIP_SHIFT +: 64];
         if (n % 2 == 1) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      sum = (sum + 64'd16384) >> 15;
      return (sum > 64'd32767) ? MAG_W'(32767) : sum[MAG_W-1:0];
   endfunction

endpackage

[sv/rrog_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrog_fifo
// Small synchronous queue with full and empty flags.
// ----------------------------------------------------------------------------
module rrog_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW-1:0]    rd_ptr_in;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[sv/rrog_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrog_front
// Control registers and classification of incoming beats.
// ----------------------------------------------------------------------------
module rrog_front import rrog_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  req_type                req,
   output cmd_type                cmd
);

   logic [CNT_W-1:0]  sensor_count_ff;
   logic [DIST_W-1:0] angle_step_ff;
   logic [DIST_W-1:0] range_limit_ff;
   logic [DIST_W-1:0] robot_radius_ff;
   logic [INDEX_W+DIST_W-1:0] angle_full;
   logic              index_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_count_ff <= RESET_SENSOR_COUNT;
         angle_step_ff   <= RESET_ANGLE_STEP;
         range_limit_ff  <= RESET_RANGE_LIMIT;
         robot_radius_ff <= RESET_ROBOT_RADIUS;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SENSOR_COUNT: sensor_count_ff <= csr_data[CNT_W-1:0];
            CSR_ANGLE_STEP:   angle_step_ff   <= csr_data;
            CSR_RANGE_LIMIT:  range_limit_ff  <= csr_data;
            CSR_ROBOT_RADIUS: robot_radius_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign index_ok   = {1'b0, req.sensor_index} < sensor_count_ff;
   assign angle_full = (INDEX_W+DIST_W)'(req.sensor_index) * (INDEX_W+DIST_W)'(angle_step_ff);

   always_comb begin
      cmd.action     = req.action;
      cmd.angle      = angle_full[DIST_W-1:0];
      cmd.radius     = RADIUS_W'(req.distance) + RADIUS_W'(robot_radius_ff);
      cmd.row_select = req.row_select;
      cmd.status     = STATUS_MARKED;
      if (req.action == ACT_SAMPLE) begin
         if (!index_ok) begin
            cmd.status = STATUS_BAD_INDEX;
         end else if (req.distance > range_limit_ff) begin
            cmd.status = STATUS_BEYOND;
         end
      end
   end

endmodule

[sv/rrog_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrog_back
// Sine lookup, radius scaling, cell rounding and the occupancy grid memory.
// ----------------------------------------------------------------------------
module rrog_back import rrog_pkg::*; #(
   parameter int GRID_SIZE       = 21,
   parameter int SINE_TABLE_BITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    out_full,
   output logic    out_push,
   output rsp_type out_item
);

   localparam int STB       = SINE_TABLE_BITS;
   localparam int QUARTER   = 1 << (STB - 2);
   localparam int LUT_AW    = STB - 1;
   localparam int HALF_STEP = 1 << (15 - STB);
   localparam int AW        = $clog2(GRID_SIZE);
   localparam int CENTER    = GRID_SIZE / 2;
   localparam int ROUND_ADD = 1 << (ROUND_SHIFT - 1);

   logic [MAG_W-1:0] sine_lut [QUARTER+1];

   for (genvar g = 0; g <= QUARTER; g++) begin : g_sine
      assign sine_lut[g] = quarter_sine(g, STB);
   end

   logic adv;
   assign adv     = !out_full;
   assign cmd_pop = adv && cmd_valid;

   // lookup
   logic [DIST_W:0]     k_sum;
   logic [STB-1:0]      k_sin;
   logic [STB-1:0]      k_cos;
   logic [LUT_AW-1:0]   r_sin;
   logic [LUT_AW-1:0]   r_cos;

   always_comb begin
      k_sum = {1'b0, cmd.angle} + (DIST_W+1)'(HALF_STEP);
      k_sin = k_sum[15 -: STB];
      k_cos = k_sin + STB'(QUARTER);
      r_sin = {1'b0, k_sin[STB-3:0]};
      r_cos = {1'b0, k_cos[STB-3:0]};
      if (k_sin[STB-2]) begin
         r_sin = LUT_AW'(QUARTER) - r_sin;
      end
      if (k_cos[STB-2]) begin
         r_cos = LUT_AW'(QUARTER) - r_cos;
      end
   end

   logic                s1_valid_ff;
   logic [ACTION_W-1:0] s1_action_ff;
   logic [STATUS_W-1:0] s1_status_ff;
   logic [RADIUS_W-1:0] s1_radius_ff;
   logic [RSEL_W-1:0]   s1_rsel_ff;
   logic [MAG_W-1:0]    s1_mag_s_ff;
   logic [MAG_W-1:0]    s1_mag_c_ff;
   logic                s1_neg_s_ff;
   logic                s1_neg_c_ff;

   // scale
   logic                s2_valid_ff;
   logic [ACTION_W-1:0] s2_action_ff;
   logic [STATUS_W-1:0] s2_status_ff;
   logic [RSEL_W-1:0]   s2_rsel_ff;
   logic [PROD_W-1:0]   s2_prod_s_ff;
   logic [PROD_W-1:0]   s2_prod_c_ff;
   logic                s2_neg_s_ff;
   logic                s2_neg_c_ff;

   // round and place
   logic [PROD_W:0]     sum_s;
   logic [PROD_W:0]     sum_c;
   logic [POS_W-1:0]    n_s;
   logic [POS_W-1:0]    n_c;
   logic [POS_W-1:0]    row_pos;
   logic [POS_W-1:0]    col_pos;
   logic                row_ok;
   logic                col_ok;
   logic                sample_ok;
   logic                mark3;
   logic                rsel_ok3;
   logic [STATUS_W-1:0] status3;
   logic [AW-1:0]       addr3;

   localparam logic [POS_W-1:0] C_POS = POS_W'(CENTER);
   localparam logic [POS_W-1:0] G_POS = POS_W'(GRID_SIZE);

   always_comb begin
      sum_s     = (PROD_W+1)'(s2_prod_s_ff) + (PROD_W+1)'(ROUND_ADD);
      sum_c     = (PROD_W+1)'(s2_prod_c_ff) + (PROD_W+1)'(ROUND_ADD);
      n_s       = POS_W'(sum_s[PROD_W:ROUND_SHIFT]);
      n_c       = POS_W'(sum_c[PROD_W:ROUND_SHIFT]);
      row_ok    = s2_neg_s_ff ? (n_s + C_POS < G_POS) : (n_s <= C_POS);
      row_pos   = s2_neg_s_ff ? C_POS + n_s : C_POS - n_s;
      col_ok    = s2_neg_c_ff ? (n_c <= C_POS) : (n_c + C_POS < G_POS);
      col_pos   = s2_neg_c_ff ? C_POS - n_c : C_POS + n_c;
      sample_ok = (s2_action_ff == ACT_SAMPLE) && (s2_status_ff == STATUS_MARKED);
      mark3     = sample_ok && row_ok && col_ok;
      status3   = (sample_ok && !(row_ok && col_ok)) ? STATUS_OFF_GRID : s2_status_ff;
      rsel_ok3  = 7'(s2_rsel_ff) < 7'(GRID_SIZE);
      if (mark3) begin
         addr3 = row_pos[AW-1:0];
      end else if ((s2_action_ff == ACT_READ) && rsel_ok3) begin
         addr3 = AW'(s2_rsel_ff);
      end else begin
         addr3 = '0;
      end
   end

   logic                s3_valid_ff;
   logic [ACTION_W-1:0] s3_action_ff;
   logic [STATUS_W-1:0] s3_status_ff;
   logic                s3_mark_ff;
   logic                s3_rsel_ok_ff;
   logic [IDX_W-1:0]    s3_row_ff;
   logic [IDX_W-1:0]    s3_col_ff;
   logic [AW-1:0]       s3_addr_ff;

   logic                s4_valid_ff;
   logic [ACTION_W-1:0] s4_action_ff;
   logic [STATUS_W-1:0] s4_status_ff;
   logic                s4_mark_ff;
   logic                s4_rsel_ok_ff;
   logic [IDX_W-1:0]    s4_row_ff;
   logic [IDX_W-1:0]    s4_col_ff;
   logic [AW-1:0]       s4_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= cmd_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_action_ff  <= cmd.action;
         s1_status_ff  <= cmd.status;
         s1_radius_ff  <= cmd.radius;
         s1_rsel_ff    <= cmd.row_select;
         s1_mag_s_ff   <= sine_lut[r_sin];
         s1_mag_c_ff   <= sine_lut[r_cos];
         s1_neg_s_ff   <= k_sin[STB-1];
         s1_neg_c_ff   <= k_cos[STB-1];

         s2_action_ff  <= s1_action_ff;
         s2_status_ff  <= s1_status_ff;
         s2_rsel_ff    <= s1_rsel_ff;
         s2_prod_s_ff  <= PROD_W'(s1_radius_ff) * PROD_W'(s1_mag_s_ff);
         s2_prod_c_ff  <= PROD_W'(s1_radius_ff) * PROD_W'(s1_mag_c_ff);
         s2_neg_s_ff   <= s1_neg_s_ff;
         s2_neg_c_ff   <= s1_neg_c_ff;

         s3_action_ff  <= s2_action_ff;
         s3_status_ff  <= status3;
         s3_mark_ff    <= mark3;
         s3_rsel_ok_ff <= rsel_ok3;
         s3_row_ff     <= row_pos[IDX_W-1:0];
         s3_col_ff     <= col_pos[IDX_W-1:0];
         s3_addr_ff    <= addr3;

         s4_action_ff  <= s3_action_ff;
         s4_status_ff  <= s3_status_ff;
         s4_mark_ff    <= s3_mark_ff;
         s4_rsel_ok_ff <= s3_rsel_ok_ff;
         s4_row_ff     <= s3_row_ff;
         s4_col_ff     <= s3_col_ff;
         s4_addr_ff    <= s3_addr_ff;
      end
   end

   // grid memory, row valid bits and one-deep write forwarding
   logic [GRID_SIZE-1:0] grid_mem [GRID_SIZE];
   logic [GRID_SIZE-1:0] rd_data_ff;
   logic [GRID_SIZE-1:0] row_valid_ff;
   logic                 fwd_valid_ff;
   logic [AW-1:0]        fwd_addr_ff;
   logic [GRID_SIZE-1:0] fwd_data_ff;
   logic [GRID_SIZE-1:0] base;
   logic [GRID_SIZE-1:0] col_bit;
   logic [GRID_SIZE-1:0] wr_data;
   logic                 wr_en;
   logic                 clear_go;
   logic [ROW_BITS_W-1:0] row_view;

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s4_addr_ff)) begin
         base = fwd_data_ff;
      end else if (row_valid_ff[s4_addr_ff]) begin
         base = rd_data_ff;
      end else begin
         base = '0;
      end
   end

   assign col_bit  = {{(GRID_SIZE-1){1'b0}}, 1'b1} << s4_col_ff[AW-1:0];
   assign wr_data  = base | col_bit;
   assign wr_en    = adv && s4_valid_ff && s4_mark_ff;
   assign clear_go = adv && s4_valid_ff && (s4_action_ff == ACT_CLEAR);

   always_ff @(posedge clock) begin
      if (adv) begin
         if (wr_en) begin
            grid_mem[s4_addr_ff] <= wr_data;
         end
         rd_data_ff <= grid_mem[s3_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (clear_go) begin
         row_valid_ff <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (wr_en) begin
         row_valid_ff[s4_addr_ff] <= 1'b1;
         fwd_valid_ff             <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_addr_ff <= s4_addr_ff;
         fwd_data_ff <= wr_data;
      end
   end

   if (GRID_SIZE >= ROW_BITS_W) begin : g_row_cut
      assign row_view = base[ROW_BITS_W-1:0];
   end else begin : g_row_pad
      assign row_view = {{(ROW_BITS_W-GRID_SIZE){1'b0}}, base};
   end

   assign out_push          = adv && s4_valid_ff;
   assign out_item.cell_row = s4_mark_ff ? s4_row_ff[CELL_W-1:0] : '0;
   assign out_item.cell_col = s4_mark_ff ? s4_col_ff[CELL_W-1:0] : '0;
   assign out_item.status   = s4_status_ff;
   assign out_item.row_bits = ((s4_action_ff == ACT_READ) && s4_rsel_ok_ff) ? row_view : '0;

`ifndef SYNTHESIS
   a_write_in_grid: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (int'(s4_addr_ff) < GRID_SIZE) && (int'(s4_col_ff) < GRID_SIZE))
      else $error("grid write outside the grid");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      clear_go |=> (row_valid_ff == '0) && !fwd_valid_ff)
      else $error("grid not empty after clear");

   a_fwd_row_valid: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> row_valid_ff[fwd_addr_ff])
      else $error("forwarded row is not marked valid");

   a_mark_from_sample: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && s4_mark_ff) |->
         (s4_action_ff == ACT_SAMPLE) && (s4_status_ff == STATUS_MARKED))
      else $error("cell marked by a beat that is not a clean sample");
`endif

endmodule

[sv/range_ring_occupancy_grid_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_ring_occupancy_grid_core
// Marks range ring readings in an occupancy grid centred on the robot.
// ----------------------------------------------------------------------------
// Request beats enter through push/full: a sample marks one grid cell, a read
// returns one grid row as a bitmap, a clear empties the grid. Every request
// gives exactly one response beat, in order, through empty/pop.
// Control registers are written through csr_write_en/csr_index/csr_data, one
// per cycle with no wait; the user must write them only while no request is
// in flight; the block does not enforce this. Throughput is one beat per
// cycle while the response queue has room. An accepted beat goes through
// the request queue, four back stages (table lookup, multiply, rounding
// with the grid read, merge with the grid write), then the response queue.
// The grid memory has one write and one read port; a row written in the
// final stage is forwarded to the beat right behind it.
// When pop is held low the response queue fills, the back stages freeze and
// then the request queue fills and raises full; nothing is lost.
// Reset restores the register defaults and empties the grid at once through
// per-row valid bits; there is no clearing pass.
// ----------------------------------------------------------------------------
module range_ring_occupancy_grid_core import rrog_pkg::*; #(
   parameter int GRID_SIZE       = 21,
   parameter int SINE_TABLE_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  req_type                req_item,
   output logic                   empty,
   input  logic                   pop,
   output rsp_type                rsp_item,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type front_cmd;
   cmd_type back_cmd;
   logic    cmd_empty;
   logic    cmd_pop;
   logic    out_full;
   logic    out_push;
   rsp_type out_item;

   rrog_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req          (req_item),
      .cmd          (front_cmd)
   );

   rrog_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (full),
      .wdata (front_cmd),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .rdata (back_cmd)
   );

   rrog_back #(
      .GRID_SIZE       (GRID_SIZE),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd       (back_cmd),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   rrog_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .full  (out_full),
      .wdata (out_item),
      .pop   (pop),
      .empty (empty),
      .rdata (rsp_item)
   );

endmodule

[tb/sv/range_ring_occupancy_grid_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_ring_occupancy_grid_core_test
// Self-checking bench for the range ring occupancy grid core.
// ----------------------------------------------------------------------------
// Sample, read-row, clear and unused beats are pushed through the request
// queue in bursts with random gaps, while the response side pops on a stall
// pattern of its own. Every accepted request is run through a local grid
// predictor (own sine table, own copy of the registers and the grid), and
// each popped response is compared field by field with the oldest predicted
// cell. Directed beats cover the power-on settings, the register extremes
// and the special cases; random sweeps under several register settings
// follow. Registers are only written once every response has been popped.
// ----------------------------------------------------------------------------
module range_ring_occupancy_grid_core_test;
   import rrog_pkg::*;

   localparam int GRID          = 21;
   localparam int CENTER        = GRID / 2;
   localparam int TRIG_BITS     = 8;
   localparam int TRIG_SIZE     = 1 << TRIG_BITS;
   localparam int TRIG_QUARTER  = 1 << (TRIG_BITS - 2);
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 4000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   full;
   req_type                req_item = '0;
   logic                   empty;
   logic                   pop = 1'b0;
   rsp_type                rsp_item;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   range_ring_occupancy_grid_core #(
      .GRID_SIZE(GRID),
      .SINE_TABLE_BITS(TRIG_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_item(req_item),
      .empty(empty),
      .pop(pop),
      .rsp_item(rsp_item),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [CNT_W-1:0]  cfg_sensors = RESET_SENSOR_COUNT;
   logic [DIST_W-1:0] cfg_step    = RESET_ANGLE_STEP;
   logic [DIST_W-1:0] cfg_limit   = RESET_RANGE_LIMIT;
   logic [DIST_W-1:0] cfg_radius  = RESET_ROBOT_RADIUS;
   logic [GRID-1:0]   occ_grid [GRID];
   int                wave_mag [TRIG_QUARTER + 1];
   rsp_type           expected_cells [$];

   int errors    = 0;
   int idle_run  = 0;
   int rx_cycle  = 0;
   int burst_left = 0;
   bit tx_steady = 1'b0;

   function automatic int quarter_wave_q15(input int unsigned r);
      longint unsigned ang, ang2, t, acc, den;
      ang  = (64'(r) * PI_HALF_Q30) >> (TRIG_BITS - 2);
      ang2 = (ang * ang) >> 30;
      t    = ang;
      acc  = ang;
      for (int k = 1; k <= 6; k++) begin
         den = 64'((2 * k) * (2 * k + 1));
         t   = ((t * ang2) >> 30) / den;
         if (k % 2 == 1) begin
            acc = (acc >= t) ? acc - t : 64'd0;
         end else begin
            acc = acc + t;
         end
      end
      acc = (acc + 64'd16384) >> 15;
      return (acc > 64'd32767) ? 32767 : int'(acc);
   endfunction

   function automatic int trig_at(input int unsigned k);
      int unsigned q, rr;
      k  = k & (TRIG_SIZE - 1);
      q  = (k >> (TRIG_BITS - 2)) & 3;
      rr = k & (TRIG_QUARTER - 1);
      if (q & 1) rr = TRIG_QUARTER - rr;
      return (q >= 2) ? -wave_mag[rr] : wave_mag[rr];
   endfunction

   // round(radius * trig / 2^21), halves away from zero
   function automatic int cell_shift(input int unsigned radius, input int trig);
      longint unsigned mag;
      int n;
      mag = 64'(radius) * 64'((trig < 0) ? -trig : trig);
      n   = int'((mag + (64'd1 << 20)) >> 21);
      return (trig < 0) ? -n : n;
   endfunction

   function automatic rsp_type predict_cell(input req_type it);
      rsp_type o;
      int unsigned ang, k, radius;
      int r, c;
      o = '0;
      case (it.action)
         ACT_SAMPLE: begin
            if (CNT_W'(it.sensor_index) >= cfg_sensors) begin
               o.status = STATUS_BAD_INDEX;
            end else if (it.distance > cfg_limit) begin
               o.status = STATUS_BEYOND;
            end else begin
               ang    = (int'(it.sensor_index) * int'(cfg_step)) & 32'hFFFF;
               k      = (ang + (1 << (15 - TRIG_BITS))) >> (16 - TRIG_BITS);
               radius = int'(it.distance) + int'(cfg_radius);
               r = CENTER - cell_shift(radius, trig_at(k));
               c = CENTER + cell_shift(radius, trig_at(k + TRIG_QUARTER));
               if (r < 0 || r >= GRID || c < 0 || c >= GRID) begin
                  o.status = STATUS_OFF_GRID;
               end else begin
                  occ_grid[r][c] = 1'b1;
                  o.status   = STATUS_MARKED;
                  o.cell_row = CELL_W'(r);
                  o.cell_col = CELL_W'(c);
               end
            end
         end
         ACT_READ: begin
            if (it.row_select < GRID) o.row_bits = ROW_BITS_W'(occ_grid[it.row_select]);
         end
         ACT_CLEAR: begin
            for (int i = 0; i < GRID; i++) occ_grid[i] = '0;
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic req_type make_req(input logic [ACTION_W-1:0] act,
                                        input int idx, input int reading, input int rsel);
      req_type it;
      it.action       = act;
      it.sensor_index = INDEX_W'(idx);
      it.distance     = DIST_W'(reading);
      it.row_select   = RSEL_W'(rsel);
      return it;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $realtime, msg);
      errors++;
   endtask

   // sender pacing: bursts of random length, random gaps
   task automatic pace();
      int gap;
      if (tx_steady) return;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(6, 1);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(80, 40)
                                                  : $urandom_range(20, 0);
      end
   endtask

   task automatic send_beat(input req_type it);
      push     <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (full);
      expected_cells.push_back(predict_cell(it));
      pace();
   endtask

   task automatic drain_results();
      push <= 1'b0;
      @(posedge clock);
      while (expected_cells.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_SENSOR_COUNT: cfg_sensors = value[CNT_W-1:0];
         CSR_ANGLE_STEP:   cfg_step    = value;
         CSR_RANGE_LIMIT:  cfg_limit   = value;
         CSR_ROBOT_RADIUS: cfg_radius  = value;
         default: ;
      endcase
   endtask

   task automatic write_all(input int sensors, input int step, input int lim, input int rad);
      drain_results();
      write_reg(CSR_SENSOR_COUNT, CSR_DATA_W'(sensors));
      write_reg(CSR_ANGLE_STEP, CSR_DATA_W'(step));
      write_reg(CSR_RANGE_LIMIT, CSR_DATA_W'(lim));
      write_reg(CSR_ROBOT_RADIUS, CSR_DATA_W'(rad));
   endtask

   function automatic req_type random_beat();
      int p, w, idx, reading, rsel, cap;
      p = $urandom_range(99, 0);
      w = $urandom_range(99, 0);
      if (p < 66) begin
         if ($urandom_range(9, 0) < 8 && cfg_sensors != 0) begin
            idx = $urandom_range((cfg_sensors > 256) ? 255 : int'(cfg_sensors) - 1, 0);
         end else begin
            idx = $urandom_range(255, 0);
         end
         cap = (cfg_limit < 700) ? int'(cfg_limit) : 700;
         if (w < 70) reading = $urandom_range(cap, 0);
         else if (w < 85) reading = int'(cfg_limit) + $urandom_range(2, 0) - 1;
         else reading = $urandom_range(65535, 0);
         return make_req(ACT_SAMPLE, idx, reading, $urandom_range(31, 0));
      end
      rsel = (w < 85) ? $urandom_range(GRID - 1, 0) : $urandom_range(31, 0);
      if (p < 96) return make_req(ACT_READ, $urandom_range(255, 0),
                                  $urandom_range(65535, 0), rsel);
      if (p < 98) return make_req(ACT_CLEAR, $urandom_range(255, 0),
                                  $urandom_range(65535, 0), rsel);
      return make_req(ACT_UNUSED, $urandom_range(255, 0), $urandom_range(65535, 0), rsel);
   endfunction

   task automatic test_power_on_settings();
      tx_steady = 1'b1;
      send_beat(make_req(ACT_SAMPLE, 0, 0, 0));
      send_beat(make_req(ACT_SAMPLE, 0, 512, 0));
      send_beat(make_req(ACT_SAMPLE, 0, 513, 0));
      send_beat(make_req(ACT_SAMPLE, 1, 300, 0));
      send_beat(make_req(ACT_SAMPLE, 2, 512, 0));
      send_beat(make_req(ACT_SAMPLE, 3, 65535, 0));
      send_beat(make_req(ACT_SAMPLE, 4, 512, 31));
      send_beat(make_req(ACT_SAMPLE, 5, 200, 0));
      send_beat(make_req(ACT_SAMPLE, 6, 512, 0));
      send_beat(make_req(ACT_SAMPLE, 7, 100, 0));
      send_beat(make_req(ACT_SAMPLE, 8, 0, 0));
      send_beat(make_req(ACT_SAMPLE, 255, 65535, 31));
      // mark then read the same row right behind it
      send_beat(make_req(ACT_SAMPLE, 0, 256, 0));
      send_beat(make_req(ACT_READ, 0, 0, CENTER));
      send_beat(make_req(ACT_READ, 255, 65535, 0));
      send_beat(make_req(ACT_READ, 0, 0, GRID - 1));
      send_beat(make_req(ACT_READ, 0, 0, GRID));
      send_beat(make_req(ACT_READ, 0, 0, 31));
      send_beat(make_req(ACT_UNUSED, 255, 65535, 31));
      send_beat(make_req(ACT_CLEAR, 255, 65535, 31));
      send_beat(make_req(ACT_READ, 0, 0, CENTER));
      send_beat(make_req(ACT_READ, 0, 0, 0));
      tx_steady = 1'b0;
      drain_results();
   endtask

   task automatic test_register_extremes();
      write_all(0, 8192, 512, 128);
      send_beat(make_req(ACT_SAMPLE, 0, 0, 0));
      send_beat(make_req(ACT_SAMPLE, 255, 100, 0));
      write_all(256, 65535, 65535, 65535);
      send_beat(make_req(ACT_SAMPLE, 255, 65535, 0));
      send_beat(make_req(ACT_SAMPLE, 0, 0, 0));
      send_beat(make_req(ACT_SAMPLE, 128, 40000, 0));
      // zero radius lands on the centre cell
      write_all(256, 0, 0, 0);
      send_beat(make_req(ACT_SAMPLE, 5, 0, 0));
      send_beat(make_req(ACT_SAMPLE, 5, 1, 0));
      send_beat(make_req(ACT_READ, 0, 0, CENTER));
      drain_results();
      write_reg(CSR_SENSOR_COUNT, 16'hFE03);
      write_reg(CSR_ANGLE_STEP, 16'd1);
      write_reg(CSR_RANGE_LIMIT, 16'd700);
      send_beat(make_req(ACT_SAMPLE, 2, 640, 0));
      send_beat(make_req(ACT_SAMPLE, 3, 640, 0));
      send_beat(make_req(ACT_READ, 0, 0, CENTER));
      drain_results();
   endtask

   task automatic test_random_sweeps();
      int sensors, step, lim, rad;
      for (int ph = 0; ph < 8; ph++) begin
         sensors = ($urandom_range(1, 0) == 0) ? $urandom_range(16, 1) : $urandom_range(256, 1);
         step    = ($urandom_range(1, 0) == 0) ? 65536 / sensors + $urandom_range(8, 0) - 4
                                               : $urandom_range(65535, 0);
         lim     = ($urandom_range(9, 0) < 7) ? $urandom_range(900, 300)
                                              : $urandom_range(65535, 0);
         rad     = ($urandom_range(9, 0) < 8) ? $urandom_range(200, 0)
                                              : $urandom_range(65535, 0);
         write_all(sensors, step & 16'hFFFF, lim, rad);
         tx_steady = (ph == 2);
         for (int n = 0; n < 65; n++) begin
            if (ph == 4 && n == 35) drain_results();
            send_beat(random_beat());
         end
         tx_steady = 1'b0;
      end
      drain_results();
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         case ((rx_cycle / 300) % 4)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(1, 0));
            2: pop <= ($urandom_range(7, 0) == 0);
            default: pop <= ((rx_cycle % 32) < 12);
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (expected_cells.size() == 0) begin
            report_mismatch($sformatf("unexpected beat %h", rsp_item));
         end else begin
            want = expected_cells.pop_front();
            if (rsp_item.cell_row !== want.cell_row)
               report_mismatch($sformatf("cell_row %0d want %0d",
                                         rsp_item.cell_row, want.cell_row));
            if (rsp_item.cell_col !== want.cell_col)
               report_mismatch($sformatf("cell_col %0d want %0d",
                                         rsp_item.cell_col, want.cell_col));
            if (rsp_item.status !== want.status)
               report_mismatch($sformatf("status %0d want %0d",
                                         rsp_item.status, want.status));
            if (rsp_item.row_bits !== want.row_bits)
               report_mismatch($sformatf("row_bits %h want %h",
                                         rsp_item.row_bits, want.row_bits));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_run <= 0;
      end else begin
         idle_run <= idle_run + 1;
         if (idle_run >= WATCHDOG_LIMIT) begin
            $display("range_ring_occupancy_grid_core_test: FAIL");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < GRID; i++) occ_grid[i] = '0;
      for (int r = 0; r <= TRIG_QUARTER; r++) wave_mag[r] = quarter_wave_q15(r);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_power_on_settings();
      test_register_extremes();
      test_random_sweeps();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && expected_cells.size() == 0) begin
         $display("range_ring_occupancy_grid_core_test: PASS");
      end else begin
         $display("range_ring_occupancy_grid_core_test: FAIL");
      end
      $finish;
   end

endmodule
